FILE: design/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and constants of the elevator sweep dispatcher.
// ----------------------------------------------------------------------------
package esd_pkg;

   localparam int FLOORS_DEF      = 16;
   localparam int START_FLOOR_DEF = 1;

   localparam int CMD_W   = 2;
   localparam int FLOOR_W = 5;
   localparam int DIR_W   = 2;

   localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ARRIVE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REACHED = 2'd2;

   localparam logic [DIR_W-1:0] DIR_STAY = 2'd0;
   localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

   localparam logic KIND_NEXT = 1'b0;
   localparam logic KIND_IDLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEEK,
      ST_DECIDE,
      ST_NEAR_START,
      ST_NEAR,
      ST_EMIT_NEXT,
      ST_EMIT_IDLE
   } state_type;

   typedef struct packed {
      logic load;
      logic request;
      logic arrive;
      logic reached;
      logic retarget;
      logic go_idle;
      logic near_start;
      logic scan_step;
      logic emit;
      logic emit_idle;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             req_ok;
      logic             reach_ok;
      logic             busy;
      logic             scan_done;
      logic             at_target;
      logic             cand_zero;
      logic             out_free;
   } dp_sts_type;

endpackage

FILE: design/esd_ctrl.sv
// ----------------------------------------------------------------------------
// esd_ctrl
// Sequencer: decodes a request, runs the floor scans and issues the result.
// ----------------------------------------------------------------------------
module esd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  esd_pkg::dp_sts_type sts,
   output esd_pkg::dp_cmd_type cmd
);
   import esd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = reset || (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            case (sts.cmd)
               CMD_REQUEST: begin
                  if (sts.req_ok) begin
                     cmd.request = 1'b1;
                     state_in    = ST_NEAR_START;
                  end
               end
               CMD_ARRIVE: begin
                  if (sts.busy) begin
                     cmd.arrive = 1'b1;
                     state_in   = ST_SEEK;
                  end
               end
               CMD_REACHED: begin
                  cmd.reached = sts.reach_ok;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SEEK: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.at_target && sts.cand_zero) begin
               cmd.go_idle = 1'b1;
               state_in    = ST_EMIT_IDLE;
            end else begin
               cmd.retarget = sts.at_target;
               state_in     = ST_NEAR_START;
            end
         end
         ST_NEAR_START: begin
            cmd.near_start = 1'b1;
            state_in       = ST_NEAR;
         end
         ST_NEAR: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_EMIT_NEXT;
            end
         end
         ST_EMIT_NEXT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_IDLE: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_idle = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/esd_dp.sv
// ----------------------------------------------------------------------------
// esd_dp
// Datapath: request bitmap, car state, bit-serial floor scanner and
// result register.
// ----------------------------------------------------------------------------
module esd_dp #(
   parameter int FLOORS          = esd_pkg::FLOORS_DEF,
   parameter int START_FLOOR_NUM = esd_pkg::START_FLOOR_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [esd_pkg::CMD_W-1:0]   req_cmd,
   input  logic [esd_pkg::FLOOR_W-1:0] req_floor,
   input  esd_pkg::dp_cmd_type         cmd,
   output esd_pkg::dp_sts_type         sts,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic [esd_pkg::FLOOR_W-1:0] rsp_next_floor,
   output logic [esd_pkg::DIR_W-1:0]   rsp_heading
);
   import esd_pkg::*;

   localparam int FCW = $clog2(FLOORS + 1);
   localparam int FW  = (FCW > FLOOR_W) ? FCW : FLOOR_W;
   localparam int IW  = $clog2(FLOORS);
   localparam logic [FW-1:0] TOP_FLOOR = FW'(FLOORS);
   localparam logic [FW-1:0] ONE       = FW'(1);

   logic [CMD_W-1:0]   cmd_ff,      cmd_in;
   logic [FLOOR_W-1:0] floor_ff,    floor_in;
   logic [FLOORS-1:0]  pending_ff,  pending_in;
   logic [FW-1:0]      cur_ff,      cur_in;
   logic [FW-1:0]      target_ff,   target_in;
   logic [DIR_W-1:0]   dir_ff,      dir_in;
   logic               busy_ff,     busy_in;
   logic [FW-1:0]      idx_ff,      idx_in;
   logic [FW-1:0]      end_ff,      end_in;
   logic               up_ff,       up_in;
   logic [FW-1:0]      found_ff,    found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff,  rsp_kind_in;
   logic [FLOOR_W-1:0] rsp_floor_ff, rsp_floor_in;
   logic [DIR_W-1:0]   rsp_dir_ff,   rsp_dir_in;

   logic [FW-1:0] floor_ext;
   logic [FW-1:0] floor_m1;
   logic [FW-1:0] cur_m1;
   logic [FW-1:0] idx_m1;
   logic          floor_ok;
   logic          scan_hit;
   logic          scan_last;
   logic          extend_tgt;

   always_comb begin
      floor_ext  = FW'(floor_ff);
      floor_m1   = floor_ext - ONE;
      cur_m1     = cur_ff - ONE;
      idx_m1     = idx_ff - ONE;
      floor_ok   = (floor_ext != '0) && (floor_ext <= TOP_FLOOR);
      scan_hit   = (idx_ff != '0) && (idx_ff <= TOP_FLOOR) && pending_ff[idx_m1[IW-1:0]];
      scan_last  = (idx_ff == end_ff);
      extend_tgt = (target_ff == '0) ||
                   ((dir_ff == DIR_UP) && (floor_ext > target_ff)) ||
                   ((dir_ff == DIR_DOWN) && (floor_ext < target_ff));

      sts.cmd       = cmd_ff;
      sts.req_ok    = floor_ok && !pending_ff[floor_m1[IW-1:0]];
      sts.reach_ok  = floor_ok;
      sts.busy      = busy_ff;
      sts.scan_done = scan_hit || scan_last;
      sts.at_target = (cur_ff == target_ff);
      sts.cand_zero = (found_ff == '0);
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      floor_in     = floor_ff;
      pending_in   = pending_ff;
      cur_in       = cur_ff;
      target_in    = target_ff;
      dir_in       = dir_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      up_in        = up_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_floor_in = rsp_floor_ff;
      rsp_dir_in   = rsp_dir_ff;

      if (cmd.load) begin
         cmd_in   = req_cmd;
         floor_in = req_floor;
      end
      if (cmd.request) begin
         busy_in                          = 1'b1;
         pending_in[floor_m1[IW-1:0]]     = 1'b1;
         if (extend_tgt) begin
            target_in = floor_ext;
            dir_in    = (floor_ext < cur_ff) ? DIR_DOWN : DIR_UP;
         end
      end
      if (cmd.arrive) begin
         pending_in[cur_m1[IW-1:0]] = 1'b0;
         up_in                      = (dir_ff == DIR_UP);
         idx_in                     = (dir_ff == DIR_UP) ? ONE : TOP_FLOOR;
         end_in                     = cur_ff;
      end
      if (cmd.reached) begin
         busy_in = 1'b1;
         cur_in  = floor_ext;
      end
      if (cmd.retarget) begin
         target_in = found_ff;
         dir_in    = (found_ff < cur_ff) ? DIR_DOWN : DIR_UP;
      end
      if (cmd.go_idle) begin
         busy_in   = 1'b0;
         target_in = '0;
         dir_in    = DIR_STAY;
      end
      if (cmd.near_start) begin
         up_in  = (target_ff > cur_ff);
         idx_in = cur_ff;
         end_in = target_ff;
      end
      if (cmd.scan_step) begin
         if (scan_hit) begin
            found_in = idx_ff;
         end else if (scan_last) begin
            found_in = '0;
         end else begin
            idx_in = up_ff ? (idx_ff + ONE) : idx_m1;
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cmd.emit_idle ? KIND_IDLE : KIND_NEXT;
         rsp_floor_in = cmd.emit_idle ? '0 : found_ff[FLOOR_W-1:0];
         rsp_dir_in   = cmd.emit_idle ? DIR_STAY : dir_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         cur_ff       <= FW'(START_FLOOR_NUM);
         target_ff    <= '0;
         dir_ff       <= DIR_STAY;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         cur_ff       <= cur_in;
         target_ff    <= target_in;
         dir_ff       <= dir_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      floor_ff     <= floor_in;
      idx_ff       <= idx_in;
      end_ff       <= end_in;
      up_ff        <= up_in;
      found_ff     <= found_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_floor_ff <= rsp_floor_in;
      rsp_dir_ff   <= rsp_dir_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_next_floor = rsp_floor_ff;
   assign rsp_heading    = rsp_dir_ff;

endmodule

FILE: design/elevator_sweep_dispatcher.sv
// ----------------------------------------------------------------------------
// elevator_sweep_dispatcher
// Sweep-style elevator dispatcher: floor requests, arrivals and floor reports
// in, next-target or all-served announcements out.
// ----------------------------------------------------------------------------
// An item without result is only decoded; a request runs one floor scan and an
// arrival up to two, each on the one-bit-per-cycle floor scanner. One item at
// a time: a new item is taken only after the previous one is finished.
// A finished result sits in the output register while the next item is taken.
// Reset (synchronous) clears the bitmap, target and heading; car at start floor.
module elevator_sweep_dispatcher #(
   parameter int FLOORS          = esd_pkg::FLOORS_DEF,
   parameter int START_FLOOR_NUM = esd_pkg::START_FLOOR_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [esd_pkg::CMD_W-1:0]   req_cmd,
   input  logic [esd_pkg::FLOOR_W-1:0] req_floor,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic [esd_pkg::FLOOR_W-1:0] rsp_next_floor,
   output logic [esd_pkg::DIR_W-1:0]   rsp_heading
);
   import esd_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   esd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   esd_dp #(
      .FLOORS          (FLOORS),
      .START_FLOOR_NUM (START_FLOOR_NUM)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_floor      (req_floor),
      .cmd            (dp_cmd),
      .sts            (dp_sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_next_floor (rsp_next_floor),
      .rsp_heading    (rsp_heading)
   );

endmodule

FILE: design/esd_checker.sv
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks of the elevator sweep dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module esd_checker #(
   parameter int FLOORS = esd_pkg::FLOORS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [esd_pkg::CMD_W-1:0]   req_cmd,
   input logic [esd_pkg::FLOOR_W-1:0] req_floor,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_kind,
   input logic [esd_pkg::FLOOR_W-1:0] rsp_next_floor,
   input logic [esd_pkg::DIR_W-1:0]   rsp_heading
);
   import esd_pkg::*;

   logic [6:0] floor_lim;
   assign floor_lim = 7'(FLOORS);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_next_floor) && $stable(rsp_heading))
      else $error("stalled result changed");

   a_idle_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_IDLE) |->
      (rsp_next_floor == '0) && (rsp_heading == DIR_STAY))
      else $error("all-served result carries a floor or heading");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in work");

   a_floor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b00, rsp_next_floor} <= floor_lim) &&
      (rsp_heading == DIR_STAY || rsp_heading == DIR_UP || rsp_heading == DIR_DOWN))
      else $error("result floor or heading out of range");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> $stable(req_cmd) && $stable(req_floor))
      else $error("stalled request changed");

endmodule

bind elevator_sweep_dispatcher esd_checker #(.FLOORS(FLOORS)) u_esd_checker (.*);
